@@ rtl/rtsm_pkg.sv @@
// ----------------------------------------------------------------------------
// rtsm_pkg
// Shared types and constants for the relative text search matcher.
// ----------------------------------------------------------------------------
package rtsm_pkg;

  localparam int BYTE_W        = 8;
  localparam int SYM_W         = 16;
  localparam int BASE_W        = 17;
  localparam int IDX_W         = 5;
  localparam int CHAR_W        = 8;
  localparam int LEN_W         = 5;
  localparam int PATTERN_SLOTS = 16;
  localparam int OUT_OFFSET_W  = 32;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 64;

  // pattern char encoding
  localparam int CHAR_WILD_BIT  = 7;
  localparam int CHAR_UPPER_BIT = 5;

  localparam logic [BASE_W-1:0] BASE_NONE = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHARS_LOW  = 3'd0,
    REG_CHARS_HIGH = 3'd1,
    REG_LENGTH     = 3'd2,
    REG_WIDE       = 3'd3,
    REG_BIG_ENDIAN = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic             care;
    logic             upper;
    logic             neg;
    logic [SYM_W-1:0] base;
  } cell_res_t;

  typedef struct packed {
    logic             match;
    logic             upper_set;
    logic             lower_set;
    logic [SYM_W-1:0] upper_base;
    logic [SYM_W-1:0] lower_base;
  } check_res_t;

endpackage

@@ rtl/rtsm_if.sv @@
// ----------------------------------------------------------------------------
// rtsm_if
// Channel interfaces: byte stream in, match results out, config writes.
// ----------------------------------------------------------------------------
interface rtsm_stream_if;
  import rtsm_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              stream_start;

  modport source (output valid, data_byte, stream_start, input ready);
  modport sink   (input valid, data_byte, stream_start, output ready);
endinterface

interface rtsm_result_if;
  import rtsm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OUT_OFFSET_W-1:0] match_offset;
  logic signed [BASE_W-1:0] upper_base;
  logic signed [BASE_W-1:0] lower_base;

  modport source (output valid, match_offset, upper_base, lower_base, input ready);
  modport sink   (input valid, match_offset, upper_base, lower_base, output ready);
endinterface

interface rtsm_cfg_if;
  import rtsm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/relative_text_search_matcher.sv @@
// ----------------------------------------------------------------------------
// relative_text_search_matcher
// Relative search over a byte stream with a pattern of letter indices.
// A byte taken from the stream passes the history, cell result and check result
//   registers before any result word for it is loaded into the result register.
// Throughput: one byte per cycle; the whole pipe holds only while the result
//   register has a word not yet taken.
// Reset: synchronous; config returns to defaults, counters and pipe clear.
//   History bytes are not cleared; the fill count masks them.
// ----------------------------------------------------------------------------
module relative_text_search_matcher #(
  parameter int MAX_PATTERN = 16,
  parameter int OFFSET_BITS = 32
) (
  input  logic         clk,
  input  logic         rst,
  rtsm_stream_if.sink  stream,
  rtsm_result_if.source result,
  rtsm_cfg_if.sink     cfg
);
  import rtsm_pkg::*;

  localparam int DEPTH  = 2 * MAX_PATTERN;
  localparam int SPAN_W = $clog2(DEPTH + 1);
  localparam int PLEN_W = $clog2(MAX_PATTERN + 1);

  // config
  logic [CFG_DATA_W-1:0] chars_low;
  logic [CFG_DATA_W-1:0] chars_high;
  logic [LEN_W-1:0]      pattern_length;
  logic                  wide_symbols;
  logic                  big_endian;

  logic [PATTERN_SLOTS*CHAR_W-1:0] chars;
  logic [PLEN_W-1:0]               len;
  logic [SPAN_W-1:0]               span;
  logic [SPAN_W-1:0]               shift_bytes;

  // handshake
  logic advance;
  logic take;

  // front end
  logic [OFFSET_BITS-1:0] pos;
  logic [OFFSET_BITS-1:0] pos_base;
  logic [OFFSET_BITS-1:0] pos_next;
  logic [OFFSET_BITS-1:0] start_next;
  logic [SPAN_W-1:0]      fill;
  logic [SPAN_W-1:0]      fill_base;
  logic [SPAN_W-1:0]      fill_next;

  // pipe tokens
  logic                   s1_valid, s2_valid, s3_valid;
  logic [OFFSET_BITS-1:0] s1_start, s2_start, s3_start;
  logic                   s1_full, s2_full, s3_full;
  logic                   s1_restart, s2_restart, s3_restart;

  // window
  logic [BYTE_W-1:0]       hist    [DEPTH];
  logic [BYTE_W-1:0]       aligned [DEPTH];
  logic [DEPTH*BYTE_W-1:0] hist_flat;
  logic [DEPTH*BYTE_W-1:0] aligned_flat;

  cell_res_t [MAX_PATTERN-1:0] cell_res;
  check_res_t                  chk;

  // gating and result
  logic [OFFSET_BITS-1:0] allowed_start;
  logic [OFFSET_BITS-1:0] allowed_base;
  logic [OFFSET_BITS-1:0] allowed_next;
  logic [OFFSET_BITS-1:0] gap;
  logic                   blocked;
  logic                   eligible;
  logic                   emit;

  logic                    out_valid;
  logic [OUT_OFFSET_W-1:0] out_offset;
  logic [BASE_W-1:0]       out_upper;
  logic [BASE_W-1:0]       out_lower;

  // ---------------- config port ----------------
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      chars_low      <= '0;
      chars_high     <= '0;
      pattern_length <= LEN_W'(1);
      wide_symbols   <= 1'b0;
      big_endian     <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_CHARS_LOW:  chars_low      <= cfg.data;
        REG_CHARS_HIGH: chars_high     <= cfg.data;
        REG_LENGTH:     pattern_length <= cfg.data[LEN_W-1:0];
        REG_WIDE:       wide_symbols   <= cfg.data[0];
        REG_BIG_ENDIAN: big_endian     <= cfg.data[0];
        default: ;
      endcase
    end
  end

  assign chars = {chars_high, chars_low};

  always_comb begin
    if (pattern_length == '0) begin
      len = PLEN_W'(1);
    end else if (pattern_length > LEN_W'(MAX_PATTERN)) begin
      len = PLEN_W'(MAX_PATTERN);
    end else begin
      len = pattern_length[PLEN_W-1:0];
    end
    span        = wide_symbols ? SPAN_W'({len, 1'b0}) : SPAN_W'(len);
    shift_bytes = SPAN_W'(DEPTH) - span;
  end

  // ---------------- handshake ----------------
  assign advance      = !out_valid || result.ready;
  assign stream.ready = advance;
  assign take         = stream.valid && advance;

  // ---------------- byte counting ----------------
  always_comb begin
    pos_base   = stream.stream_start ? '0 : pos;
    fill_base  = stream.stream_start ? '0 : fill;
    pos_next   = pos_base + OFFSET_BITS'(1);
    fill_next  = (fill_base == SPAN_W'(DEPTH)) ? fill_base : fill_base + SPAN_W'(1);
    start_next = pos_next - OFFSET_BITS'(span);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      fill <= '0;
    end else if (take) begin
      pos  <= pos_next;
      fill <= fill_next;
    end
  end

  // ---------------- pipe tokens ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= take;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_start   <= start_next;
      s1_full    <= fill_next >= span;
      s1_restart <= stream.stream_start;
      s2_start   <= s1_start;
      s2_full    <= s1_full;
      s2_restart <= s1_restart;
      s3_start   <= s2_start;
      s3_full    <= s2_full;
      s3_restart <= s2_restart;
    end
  end

  // ---------------- cell row ----------------
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      hist_flat[i*BYTE_W +: BYTE_W] = hist[i];
    end
    // oldest byte of the candidate lands in the top slot
    aligned_flat = hist_flat << (shift_bytes * BYTE_W);
    for (int i = 0; i < DEPTH; i++) begin
      aligned[i] = aligned_flat[(DEPTH-1-i)*BYTE_W +: BYTE_W];
    end
  end

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic [BYTE_W-1:0] chain_in;

    if (k == 0) begin : g_head
      assign chain_in = stream.data_byte;
    end else begin : g_link
      assign chain_in = hist[2*k-1];
    end

    rtsm_cell u_cell (
      .clk          (clk),
      .shift        (take),
      .advance      (advance),
      .byte_in      (chain_in),
      .hist_near    (hist[2*k]),
      .hist_far     (hist[2*k+1]),
      .sym_narrow   (aligned[k]),
      .sym_first    (aligned[2*k]),
      .sym_second   (aligned[2*k+1]),
      .pattern_char (chars[k*CHAR_W +: CHAR_W]),
      .active       (PLEN_W'(k) < len),
      .wide         (wide_symbols),
      .big_endian   (big_endian),
      .res          (cell_res[k])
    );
  end

  rtsm_check #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_check (
    .clk     (clk),
    .advance (advance),
    .cells   (cell_res),
    .res     (chk)
  );

  // ---------------- gating ----------------
  always_comb begin
    allowed_base = s3_restart ? '0 : allowed_start;
    gap          = allowed_base - s3_start;
    blocked      = (gap != '0) && (gap <= OFFSET_BITS'(DEPTH));
    eligible     = s3_valid && s3_full && !blocked;
    emit         = eligible && chk.match;
    if (eligible) begin
      allowed_next = chk.match ? s3_start + OFFSET_BITS'(span)
                               : s3_start + OFFSET_BITS'(1);
    end else begin
      allowed_next = allowed_base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      allowed_start <= '0;
    end else if (advance && s3_valid) begin
      allowed_start <= allowed_next;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_offset <= OUT_OFFSET_W'(s3_start);
      out_upper  <= chk.upper_set ? {1'b0, chk.upper_base} : BASE_NONE;
      out_lower  <= chk.lower_set ? {1'b0, chk.lower_base} : BASE_NONE;
    end
  end

  assign result.valid        = out_valid;
  assign result.match_offset = out_offset;
  assign result.upper_base   = out_upper;
  assign result.lower_base   = out_lower;

`ifndef ASSERT_OFF
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= SPAN_W'(DEPTH))
    else $error("fill count beyond window depth");

  a_base_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((!out_upper[BASE_W-1] || out_upper == BASE_NONE) &&
                   (!out_lower[BASE_W-1] || out_lower == BASE_NONE)))
    else $error("base out of range");

  a_word_source: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid)) |-> $past(s3_valid && chk.match))
    else $error("result word without a matching candidate");

  a_skip_span: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(advance && emit)) |->
      (allowed_start == $past(s3_start) + OFFSET_BITS'($past(span))))
    else $error("match did not move the allowed start past its span");
`endif

endmodule

@@ rtl/rtsm_cell.sv @@
// ----------------------------------------------------------------------------
// rtsm_cell
// One pattern slot: holds two history bytes, passing the older on to the next
// slot, and registers the relative base of its pattern char against the window.
// ----------------------------------------------------------------------------
module rtsm_cell (
  input  logic                          clk,
  input  logic                          shift,
  input  logic                          advance,
  input  logic [rtsm_pkg::BYTE_W-1:0]   byte_in,
  output logic [rtsm_pkg::BYTE_W-1:0]   hist_near,
  output logic [rtsm_pkg::BYTE_W-1:0]   hist_far,
  input  logic [rtsm_pkg::BYTE_W-1:0]   sym_narrow,
  input  logic [rtsm_pkg::BYTE_W-1:0]   sym_first,
  input  logic [rtsm_pkg::BYTE_W-1:0]   sym_second,
  input  logic [rtsm_pkg::CHAR_W-1:0]   pattern_char,
  input  logic                          active,
  input  logic                          wide,
  input  logic                          big_endian,
  output rtsm_pkg::cell_res_t           res
);
  import rtsm_pkg::*;

  logic [BYTE_W-1:0] hist_new;
  logic [BYTE_W-1:0] hist_old;
  logic [SYM_W-1:0]  sym;
  logic [BASE_W-1:0] diff;
  cell_res_t         res_next;

  always_comb begin
    if (wide) begin
      sym = big_endian ? {sym_first, sym_second} : {sym_second, sym_first};
    end else begin
      sym = {{(SYM_W-BYTE_W){1'b0}}, sym_narrow};
    end
    diff = {1'b0, sym} - BASE_W'(pattern_char[IDX_W-1:0]);
    res_next.care  = active && !pattern_char[CHAR_WILD_BIT];
    res_next.upper = pattern_char[CHAR_UPPER_BIT];
    res_next.neg   = diff[BASE_W-1];
    res_next.base  = diff[SYM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      hist_new <= byte_in;
      hist_old <= hist_new;
    end
    if (advance) begin
      res <= res_next;
    end
  end

  assign hist_near = hist_new;
  assign hist_far  = hist_old;

endmodule

@@ rtl/rtsm_check.sv @@
// ----------------------------------------------------------------------------
// rtsm_check
// Agreement check over all slots: every cared-for base nonnegative, and one
// common base per letter case.
// ----------------------------------------------------------------------------
module rtsm_check #(
  parameter int MAX_PATTERN = 16
) (
  input  logic                                    clk,
  input  logic                                    advance,
  input  rtsm_pkg::cell_res_t [MAX_PATTERN-1:0]   cells,
  output rtsm_pkg::check_res_t                    res
);
  import rtsm_pkg::*;

  logic [MAX_PATTERN-1:0] upper_mask;
  logic [MAX_PATTERN-1:0] lower_mask;
  logic [MAX_PATTERN-1:0] upper_first;
  logic [MAX_PATTERN-1:0] lower_first;
  logic [MAX_PATTERN-1:0] neg_mask;
  logic [SYM_W-1:0]       upper_ref;
  logic [SYM_W-1:0]       lower_ref;
  logic                   upper_ok;
  logic                   lower_ok;
  check_res_t             res_next;

  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      upper_mask[k] = cells[k].care && cells[k].upper;
      lower_mask[k] = cells[k].care && !cells[k].upper;
      neg_mask[k]   = cells[k].care && cells[k].neg;
    end
    // lowest set bit picks the reference slot
    upper_first = upper_mask & (~upper_mask + MAX_PATTERN'(1));
    lower_first = lower_mask & (~lower_mask + MAX_PATTERN'(1));
    upper_ref = '0;
    lower_ref = '0;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      upper_ref = upper_ref | ({SYM_W{upper_first[k]}} & cells[k].base);
      lower_ref = lower_ref | ({SYM_W{lower_first[k]}} & cells[k].base);
    end
    upper_ok = 1'b1;
    lower_ok = 1'b1;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (upper_mask[k] && (cells[k].base != upper_ref)) upper_ok = 1'b0;
      if (lower_mask[k] && (cells[k].base != lower_ref)) lower_ok = 1'b0;
    end
    res_next.match      = (neg_mask == '0) && upper_ok && lower_ok;
    res_next.upper_set  = |upper_mask;
    res_next.lower_set  = |lower_mask;
    res_next.upper_base = upper_ref;
    res_next.lower_base = lower_ref;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

endmodule
